@@ rtl/rcfd_pkg.sv @@
// ============================================================================
// rcfd_pkg - shared definitions for the RC link frame channel decoder
// Frame geometry, status codes, register indexes and the CRC-8 step.
// ============================================================================
package rcfd_pkg;

  localparam int NUM_CHANNELS  = 16;
  localparam int CHANNEL_BITS  = 11;
  localparam int PAYLOAD_BYTES = 22;

  // Frame byte positions holding the payload.
  localparam int PAYLOAD_FIRST = 3;
  localparam int PAYLOAD_END   = PAYLOAD_FIRST + PAYLOAD_BYTES;

  localparam int POS_W     = 9;
  localparam int PAY_IDX_W = $clog2(PAYLOAD_BYTES);
  localparam int CH_IDX_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CH_OUT_W  = 4;
  localparam int FLAT_W    = PAYLOAD_BYTES * 8;

  localparam logic [7:0] CRC_POLY      = 8'hD5;
  localparam logic [7:0] TICK_MAX      = 8'd255;
  localparam logic [7:0] SYNC_RESET    = 8'd200;
  localparam logic [7:0] EXP_LEN_RESET = 8'd24;
  localparam logic [7:0] MIN_LENGTH    = 8'd2;

  typedef enum logic [1:0] {
    STATUS_CHANNEL   = 2'd0,
    STATUS_CRC_ERROR = 2'd1,
    STATUS_TICK      = 2'd2
  } status_t;

  typedef enum logic {
    REG_SYNC_ADDRESS    = 1'b0,
    REG_EXPECTED_LENGTH = 1'b1
  } reg_index_t;

  typedef enum logic {
    KIND_BYTE = 1'b0,
    KIND_TICK = 1'b1
  } kind_t;

  // Payload store write request from the parser.
  typedef struct packed {
    logic                 en;
    logic [PAY_IDX_W-1:0] idx;
    logic [7:0]           data;
  } pay_wr_t;

  // One byte through the CRC-8 (MSB first, no reflection).
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ rtl/rcfd_payload.sv @@
// ============================================================================
// rcfd_payload - payload byte store and channel unpacking
// Holds frame bytes 3..24 and picks one eleven-bit channel, LSB first.
// ============================================================================
module rcfd_payload (
  input  logic                                clk,
  input  rcfd_pkg::pay_wr_t                   wr,
  input  logic [rcfd_pkg::CH_IDX_W-1:0]       rd_chan,
  output logic [rcfd_pkg::CHANNEL_BITS-1:0]   rd_value
);

  logic [7:0]                  store_r [rcfd_pkg::PAYLOAD_BYTES];
  logic [rcfd_pkg::FLAT_W-1:0] flat;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      store_r[wr.idx] <= wr.data;
    end
  end

  // Byte 0 sits at the bottom, so channel k is bits k*11 upwards.
  always_comb begin
    for (int i = 0; i < rcfd_pkg::PAYLOAD_BYTES; i++) begin
      flat[i*8 +: 8] = store_r[i];
    end
  end

  assign rd_value = flat[rd_chan*rcfd_pkg::CHANNEL_BITS +: rcfd_pkg::CHANNEL_BITS];

endmodule

@@ rtl/rc_link_frame_channel_decoder_core.sv @@
// ============================================================================
// rc_link_frame_channel_decoder_core - packed RC channel frame decoder
// Parses sync/length/data/CRC frames and emits channels, errors and ticks.
// ============================================================================
// Usage:
// The input channel (in_valid/in_ready) carries one item per received serial
// byte or timeout tick. The result channel (out_valid/out_ready) delivers
// status, channel index and value, a last flag and the timeout count.
// The cfg_ port writes the sync address and the expected frame length; write
// it only while the block is idle.
// Latency: a result appears on the cycle after the item that caused it is
// accepted; the output register frees the input side, so one item is taken
// every cycle while results are being taken and no channels are owed.
// A good frame gives 16 channel items, one per cycle from the output
// register while they are taken; the input is held off after the CRC byte
// while the channel counter walks the payload store.
// Receiver stall: the output register holds its item and in_ready drops until
// it is taken.
// Reset: hunting for sync, timeout count zero, registers at 200 and 24. The
// payload store is not cleared.
// ============================================================================
module rc_link_frame_channel_decoder_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_kind,
  input  logic [7:0]                          in_byte_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output rcfd_pkg::status_t                   out_status,
  output logic [rcfd_pkg::CH_OUT_W-1:0]       out_channel_index,
  output logic [rcfd_pkg::CHANNEL_BITS-1:0]   out_channel_value,
  output logic                                out_last,
  output logic [7:0]                          out_timeout_count,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [7:0]                          cfg_wdata
);

  logic [7:0] sync_addr_r, exp_len_r;

  logic [rcfd_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]                 len_r, len_nxt;
  logic [7:0]                 crc_r, crc_nxt;
  logic [7:0]                 tick_r, tick_nxt;

  logic                          emit_r, emit_nxt;
  logic [rcfd_pkg::CH_IDX_W-1:0] chan_r, chan_nxt;

  logic                                out_valid_r;
  rcfd_pkg::status_t                   status_r;
  logic [rcfd_pkg::CH_OUT_W-1:0]       idx_r;
  logic [rcfd_pkg::CHANNEL_BITS-1:0]   value_r;
  logic                                last_r;
  logic [7:0]                          count_r;

  logic                                in_fire, out_free;
  logic                                res_valid, res_frame;
  rcfd_pkg::status_t                   res_status;
  rcfd_pkg::pay_wr_t                   pay_wr;
  logic [rcfd_pkg::CH_IDX_W-1:0]       rd_chan;
  logic [rcfd_pkg::CHANNEL_BITS-1:0]   rd_value;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = !emit_r && out_free;
  assign in_fire  = in_valid && in_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_addr_r <= rcfd_pkg::SYNC_RESET;
      exp_len_r   <= rcfd_pkg::EXP_LEN_RESET;
    end else if (cfg_we) begin
      unique case (rcfd_pkg::reg_index_t'(cfg_index))
        rcfd_pkg::REG_SYNC_ADDRESS:    sync_addr_r <= cfg_wdata;
        rcfd_pkg::REG_EXPECTED_LENGTH: exp_len_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Frame parser: one accepted item per pass.
  always_comb begin
    pos_nxt    = pos_r;
    len_nxt    = len_r;
    crc_nxt    = crc_r;
    tick_nxt   = tick_r;
    res_valid  = 1'b0;
    res_frame  = 1'b0;
    res_status = rcfd_pkg::STATUS_TICK;
    pay_wr     = '0;
    pay_wr.data = in_byte_value;
    pay_wr.idx  = rcfd_pkg::PAY_IDX_W'(pos_r - rcfd_pkg::POS_W'(rcfd_pkg::PAYLOAD_FIRST));
    if (in_fire) begin
      if (rcfd_pkg::kind_t'(in_kind) == rcfd_pkg::KIND_TICK) begin
        if (tick_r != rcfd_pkg::TICK_MAX) begin
          tick_nxt = tick_r + 8'd1;
        end
        res_valid  = 1'b1;
        res_status = rcfd_pkg::STATUS_TICK;
      end else if (pos_r == '0) begin
        if (in_byte_value == sync_addr_r) begin
          pos_nxt = rcfd_pkg::POS_W'(1);
        end
      end else if (pos_r == rcfd_pkg::POS_W'(1)) begin
        len_nxt = in_byte_value;
        crc_nxt = '0;
        pos_nxt = (in_byte_value < rcfd_pkg::MIN_LENGTH) ? '0 : rcfd_pkg::POS_W'(2);
      end else if (pos_r <= {1'b0, len_r}) begin
        crc_nxt = rcfd_pkg::crc8_step(crc_r, in_byte_value);
        pay_wr.en = (pos_r >= rcfd_pkg::POS_W'(rcfd_pkg::PAYLOAD_FIRST)) &&
                    (pos_r <  rcfd_pkg::POS_W'(rcfd_pkg::PAYLOAD_END));
        pos_nxt = pos_r + rcfd_pkg::POS_W'(1);
      end else begin
        // This byte is the CRC and closes the frame.
        pos_nxt = '0;
        if (len_r == exp_len_r) begin
          res_valid = 1'b1;
          if (in_byte_value != crc_r) begin
            res_status = rcfd_pkg::STATUS_CRC_ERROR;
          end else begin
            res_status = rcfd_pkg::STATUS_CHANNEL;
            res_frame  = 1'b1;
            tick_nxt   = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      len_r  <= '0;
      crc_r  <= '0;
      tick_r <= '0;
    end else begin
      pos_r  <= pos_nxt;
      len_r  <= len_nxt;
      crc_r  <= crc_nxt;
      tick_r <= tick_nxt;
    end
  end

  // Channel 0 goes out with the CRC byte; the counter covers the rest.
  assign rd_chan = emit_r ? chan_r : '0;

  always_comb begin
    emit_nxt = emit_r;
    chan_nxt = chan_r;
    if (res_frame && (rcfd_pkg::NUM_CHANNELS > 1)) begin
      emit_nxt = 1'b1;
      chan_nxt = rcfd_pkg::CH_IDX_W'(1);
    end else if (emit_r && out_free) begin
      chan_nxt = chan_r + rcfd_pkg::CH_IDX_W'(1);
      if (chan_r == rcfd_pkg::CH_IDX_W'(rcfd_pkg::NUM_CHANNELS - 1)) begin
        emit_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_r <= 1'b0;
      chan_r <= '0;
    end else begin
      emit_r <= emit_nxt;
      chan_r <= chan_nxt;
    end
  end

  rcfd_payload u_payload (
    .clk      (clk),
    .wr       (pay_wr),
    .rd_chan  (rd_chan),
    .rd_value (rd_value)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((in_fire && res_valid) || (emit_r && out_free)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_r && out_free) begin
      status_r <= rcfd_pkg::STATUS_CHANNEL;
      idx_r    <= rcfd_pkg::CH_OUT_W'(chan_r);
      value_r  <= rd_value;
      last_r   <= (chan_r == rcfd_pkg::CH_IDX_W'(rcfd_pkg::NUM_CHANNELS - 1));
      count_r  <= '0;
    end else if (in_fire && res_valid) begin
      status_r <= res_status;
      idx_r    <= '0;
      value_r  <= res_frame ? rd_value : '0;
      last_r   <= !res_frame || (rcfd_pkg::NUM_CHANNELS == 1);
      count_r  <= tick_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_channel_index = idx_r;
  assign out_channel_value = value_r;
  assign out_last          = last_r;
  assign out_timeout_count = count_r;

endmodule

@@ rtl/rcfd_checker.sv @@
// ============================================================================
// rcfd_checker - port-level checks for the frame decoder
// Watches the top level's ports and flags broken result sequences.
// ============================================================================
module rcfd_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input rcfd_pkg::status_t                   out_status,
  input logic [rcfd_pkg::CH_OUT_W-1:0]       out_channel_index,
  input logic [rcfd_pkg::CHANNEL_BITS-1:0]   out_channel_value,
  input logic                                out_last,
  input logic [7:0]                          out_timeout_count
);

  // A stalled result item holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_channel_value) && $stable(out_last))
    else $error("result item changed while stalled");

  // Ticks and CRC errors are single items with zeroed channel fields.
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != rcfd_pkg::STATUS_CHANNEL |->
      out_last && out_channel_index == '0 && out_channel_value == '0)
    else $error("non-channel item malformed");

  // A good frame has just cleared the timeout count.
  a_chan_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == rcfd_pkg::STATUS_CHANNEL |-> out_timeout_count == '0)
    else $error("channel item with non-zero timeout count");

  // While channels of a frame are still owed, no input item is taken.
  a_burst_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_status == rcfd_pkg::STATUS_CHANNEL && !out_last
      |=> (out_last || !in_ready) && out_valid &&
          out_status == rcfd_pkg::STATUS_CHANNEL &&
          out_channel_index == $past(out_channel_index) + 4'd1)
    else $error("channel burst broken");

endmodule

bind rc_link_frame_channel_decoder_core rcfd_checker u_rcfd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_status        (out_status),
  .out_channel_index (out_channel_index),
  .out_channel_value (out_channel_value),
  .out_last          (out_last),
  .out_timeout_count (out_timeout_count)
);
